// ===== src/stq_pkg.sv =====
// Shared constants, codes and types of the sorted timer queue.
`default_nettype none
package stq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int TIME_BITS   = 48;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int ID_W        = 4;
    localparam int TIMEOUT_W   = 32;
    localparam int KIND_W      = 3;
    localparam int KEY_W       = (SLOT_W > ID_W) ? SLOT_W : ID_W;
    localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_CHANGE = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATED = 3'd0,
        KIND_CHANGED = 3'd1,
        KIND_DELETED = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_ARMED   = 2'd1,
        ST_EXPIRED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ACT_IDLE   = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_CMP    = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_DUE    = 3'd4,
        ACT_FIRE   = 3'd5
    } act_t;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [TIME_BITS-1:0] expiry;
    } key_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [TIME_BITS-1:0] expiry;
    } cell_t;

    typedef struct packed {
        act_t            act;
        key_t            key;
        logic [ID_W-1:0] id;
    } ctl_t;

    typedef struct packed {
        logic              found;
        logic              full;
        logic [SLOT_W-1:0] free_slot;
        logic              any_due;
        logic              multi_due;
        logic [SLOT_W-1:0] due_slot;
    } stat_t;

    localparam cell_t FREE_CELL = '{status: ST_FREE, slot: '0, expiry: '0};

endpackage
`default_nettype wire

// ===== src/stq_req_if.sv =====
// Request channel of the sorted timer queue.
`default_nettype none
interface stq_req_if;
    import stq_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  op;
    logic [ID_W-1:0]      timer_id;
    logic [TIMEOUT_W-1:0] timeout;

    modport source (output valid, output op, output timer_id, output timeout, input ready);
    modport sink (input valid, input op, input timer_id, input timeout, output ready);
endinterface
`default_nettype wire

// ===== src/stq_rsp_if.sv =====
// Result channel of the sorted timer queue.
`default_nettype none
interface stq_rsp_if;
    import stq_pkg::*;

    logic            valid;
    logic            ready;
    kind_t           kind;
    logic [ID_W-1:0] slot_id;
    logic            last;

    modport source (output valid, output kind, output slot_id, output last, input ready);
    modport sink (input valid, input kind, input slot_id, input last, output ready);
endinterface
`default_nettype wire

// ===== src/stq_cell.sv =====
// One cell of the sorted timer chain: holds one timer and trades it with its neighbors.
`default_nettype none
module stq_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire stq_pkg::ctl_t  ctl,
    input  wire stq_pkg::cell_t left_cell,
    input  wire stq_pkg::cell_t right_cell,
    input  wire logic           shift,
    input  wire logic           head,
    input  wire logic           fire,
    output stq_pkg::cell_t      contents,
    output logic                match,
    output logic                ge,
    output logic                due
);
    import stq_pkg::*;

    status_t              status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [TIME_BITS-1:0] exp_reg, exp_next;
    logic                 ge_reg, ge_next;
    logic                 due_reg, due_next;
    logic [KEY_W-1:0]     own_key, id_key;

    assign own_key = KEY_W'(slot_reg);
    assign id_key  = KEY_W'(ctl.id);
    assign match   = (status_reg != ST_FREE) && (own_key == id_key);

    always_comb
    begin
        status_next = status_reg;
        slot_next   = slot_reg;
        exp_next    = exp_reg;
        ge_next     = ge_reg;
        due_next    = due_reg;
        unique case (ctl.act)
            ACT_IDLE:
            begin
            end
            ACT_REMOVE:
            begin
                if (shift)
                begin
                    status_next = right_cell.status;
                    slot_next   = right_cell.slot;
                    exp_next    = right_cell.expiry;
                end
            end
            ACT_CMP:
            begin
                ge_next = (status_reg == ST_ARMED) && (ctl.key.expiry >= exp_reg);
            end
            ACT_INSERT:
            begin
                if (shift && head)
                begin
                    status_next = ST_ARMED;
                    slot_next   = ctl.key.slot;
                    exp_next    = ctl.key.expiry;
                end
                else if (shift)
                begin
                    status_next = left_cell.status;
                    slot_next   = left_cell.slot;
                    exp_next    = left_cell.expiry;
                end
            end
            ACT_DUE:
            begin
                due_next = (status_reg == ST_ARMED) && (exp_reg <= ctl.key.expiry);
            end
            ACT_FIRE:
            begin
                if (fire)
                begin
                    status_next = ST_EXPIRED;
                    due_next    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_FREE;
            ge_reg     <= 1'b0;
            due_reg    <= 1'b0;
        end
        else
        begin
            status_reg <= status_next;
            ge_reg     <= ge_next;
            due_reg    <= due_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        exp_reg  <= exp_next;
    end

    assign contents = '{status: status_reg, slot: slot_reg, expiry: exp_reg};
    assign ge       = ge_reg;
    assign due      = due_reg;

endmodule
`default_nettype wire

// ===== src/stq_chain.sv =====
// Row of timer cells with the shift, free-slot and due-timer logic around it.
`default_nettype none
module stq_chain (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire stq_pkg::ctl_t ctl,
    output stq_pkg::stat_t     stat
);
    import stq_pkg::*;

    cell_t                  cells [TIMER_SLOTS];
    cell_t                  left_in [TIMER_SLOTS];
    cell_t                  right_in [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] match, ge, due, shl, sfx, shr, head, shift, due_low;
    logic [TIMER_SLOTS-1:0] used;
    logic [SLOT_W-1:0]      free_slot, due_slot;

    genvar i;
    generate
        for (i = 0; i < TIMER_SLOTS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign left_in[i] = FREE_CELL;
                assign shl[i]     = match[i];
                assign head[i]    = shr[i];
            end
            else
            begin : g_rest
                assign left_in[i] = cells[i-1];
                assign shl[i]     = shl[i-1] | match[i];
                assign head[i]    = shr[i] & ~shr[i-1];
            end

            if (i == TIMER_SLOTS - 1)
            begin : g_last
                assign right_in[i] = FREE_CELL;
                assign sfx[i]      = ge[i];
            end
            else
            begin : g_inner
                assign right_in[i] = cells[i+1];
                assign sfx[i]      = ge[i] | sfx[i+1];
            end

            assign shr[i]   = ~sfx[i];
            assign shift[i] = (ctl.act == ACT_REMOVE) ? shl[i] : shr[i];

            stq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .left_cell  (left_in[i]),
                .right_cell (right_in[i]),
                .shift      (shift[i]),
                .head       (head[i]),
                .fire       (due_low[i]),
                .contents   (cells[i]),
                .match      (match[i]),
                .ge         (ge[i]),
                .due        (due[i])
            );
        end
    endgenerate

    assign due_low = due & ((~due) + TIMER_SLOTS'(1));

    always_comb
    begin
        used = '0;
        for (int k = 0; k < TIMER_SLOTS; k++)
        begin
            if (cells[k].status != ST_FREE)
            begin
                used[cells[k].slot] = 1'b1;
            end
        end
        free_slot = '0;
        for (int s = TIMER_SLOTS - 1; s >= 0; s--)
        begin
            if (!used[s])
            begin
                free_slot = SLOT_W'(s);
            end
        end
        due_slot = '0;
        for (int k = 0; k < TIMER_SLOTS; k++)
        begin
            if (due_low[k])
            begin
                due_slot = due_slot | cells[k].slot;
            end
        end
    end

    assign stat.found     = |match;
    assign stat.full      = (cells[TIMER_SLOTS-1].status != ST_FREE);
    assign stat.free_slot = free_slot;
    assign stat.any_due   = |due;
    assign stat.multi_due = (due & (due - TIMER_SLOTS'(1))) != '0;
    assign stat.due_slot  = due_slot;

endmodule
`default_nettype wire

// ===== src/sorted_timer_queue_unit.sv =====
// Top level of the sorted timer queue: command sequencer, time counter and result register.
// A delete passes S_REMOVE, a create S_CREATE and S_INSERT, a change S_REMOVE, S_CMP and
// S_INSERT; an error or a full-queue create goes straight on to S_SEND, which loads the result.
// A tick steps the time in S_IDLE and marks due cells in S_DUE, then gives one expired result
// per cycle while the result register is free, earliest first, and then returns to S_IDLE.
// Reset clears the time and marks every cell free at once; no clearing pass is needed.
`default_nettype none
module sorted_timer_queue_unit (
    input wire logic clk,
    input wire logic rst_n,
    stq_req_if.sink   req,
    stq_rsp_if.source rsp
);
    import stq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_REMOVE,
        S_CMP,
        S_INSERT,
        S_SEND,
        S_DUE,
        S_FIRE
    } state_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [TIME_BITS-1:0] exp_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [CNT_W-1:0]     n_reg;
    kind_t                res_kind_reg;
    logic [ID_W-1:0]      res_slot_reg;
    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [ID_W-1:0]      out_slot_reg;
    logic                 out_last_reg;

    ctl_t                 ctl;
    stat_t                stat;
    logic                 out_free;
    logic                 out_load;
    logic                 fire_last;
    logic [TIME_BITS:0]   exp_sum;
    logic [TIME_BITS-1:0] new_exp;
    logic [KEY_W-1:0]     id_key, slot_key, due_key;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign out_load  = ((state_reg == S_SEND) || ((state_reg == S_FIRE) && stat.any_due))
                       && out_free;
    assign exp_sum   = {1'b0, time_reg} + (TIME_BITS+1)'(req.timeout);
    assign new_exp   = exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0];
    assign id_key    = KEY_W'(id_reg);
    assign slot_key  = KEY_W'(slot_reg);
    assign due_key   = KEY_W'(stat.due_slot);
    assign fire_last = !stat.multi_due || (n_reg == CNT_W'(MAX_RESULTS - 1));

    stq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat)
    );

    always_comb
    begin
        ctl.act        = ACT_IDLE;
        ctl.key.slot   = slot_reg;
        ctl.key.expiry = exp_reg;
        ctl.id         = id_reg;
        unique case (state_reg)
            S_CREATE:
            begin
                if (!stat.full)
                begin
                    ctl.act = ACT_CMP;
                end
            end
            S_REMOVE:
            begin
                if (stat.found)
                begin
                    ctl.act = ACT_REMOVE;
                end
            end
            S_CMP:
            begin
                ctl.act = ACT_CMP;
            end
            S_INSERT:
            begin
                ctl.act = ACT_INSERT;
            end
            S_DUE:
            begin
                ctl.act        = ACT_DUE;
                ctl.key.expiry = time_reg;
            end
            S_FIRE:
            begin
                if (stat.any_due && out_free)
                begin
                    ctl.act = ACT_FIRE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !rsp.ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg  <= req.op;
                        id_reg  <= req.timer_id;
                        exp_reg <= new_exp;
                        n_reg   <= '0;
                        unique case (req.op)
                            OP_CREATE:
                            begin
                                state_reg <= S_CREATE;
                            end
                            OP_CHANGE, OP_DELETE:
                            begin
                                state_reg <= S_REMOVE;
                            end
                            OP_TICK:
                            begin
                                if (time_reg != '1)
                                begin
                                    time_reg <= time_reg + TIME_BITS'(1);
                                end
                                state_reg <= S_DUE;
                            end
                        endcase
                    end
                end
                S_CREATE:
                begin
                    if (stat.full)
                    begin
                        res_kind_reg <= KIND_ERROR;
                        res_slot_reg <= '0;
                        state_reg    <= S_SEND;
                    end
                    else
                    begin
                        slot_reg     <= stat.free_slot;
                        res_kind_reg <= KIND_CREATED;
                        state_reg    <= S_INSERT;
                    end
                end
                S_REMOVE:
                begin
                    res_slot_reg <= id_reg;
                    if (!stat.found)
                    begin
                        res_kind_reg <= KIND_ERROR;
                        state_reg    <= S_SEND;
                    end
                    else if (op_reg == OP_CHANGE)
                    begin
                        slot_reg     <= id_key[SLOT_W-1:0];
                        res_kind_reg <= KIND_CHANGED;
                        state_reg    <= S_CMP;
                    end
                    else
                    begin
                        res_kind_reg <= KIND_DELETED;
                        state_reg    <= S_SEND;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_INSERT;
                end
                S_INSERT:
                begin
                    res_slot_reg <= slot_key[ID_W-1:0];
                    state_reg    <= S_SEND;
                end
                S_SEND:
                begin
                    if (out_free)
                    begin
                        out_kind_reg  <= res_kind_reg;
                        out_slot_reg  <= res_slot_reg;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_DUE:
                begin
                    state_reg <= S_FIRE;
                end
                S_FIRE:
                begin
                    if (!stat.any_due)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_kind_reg  <= KIND_EXPIRED;
                        out_slot_reg  <= due_key[ID_W-1:0];
                        out_last_reg  <= fire_last;
                        n_reg         <= n_reg + CNT_W'(1);
                        if (fire_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.kind    = out_kind_reg;
    assign rsp.slot_id = out_slot_reg;
    assign rsp.last    = out_last_reg;

`ifndef SYNTHESIS
    a_fire_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_FIRE) |-> out_free)
        else $error("timer fired while the result register was blocked");

    a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_INSERT) |-> !stat.full)
        else $error("insert into a full chain");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> (time_reg >= $past(time_reg)))
        else $error("current time went backwards");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.kind != KIND_EXPIRED)) |-> rsp.last)
        else $error("command result not marked as last");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/sorted_timer_queue_unit_tb.sv =====
// Testbench of the sorted timer queue: directed and random requests against a predictor.
module sorted_timer_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stq_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int IDLE_PERCENT    = 11;
    localparam int RANDOM_REQUESTS = 355;
    localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] slot;
        logic            last;
    } outcome_t;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   mismatch_count;
    int   quiet_cycles;

    outcome_t pending_outcomes[$];
    outcome_t seen;

    logic [TIME_BITS-1:0] now_time = '0;
    logic [SLOT_W-1:0]    chain_slot[TIMER_SLOTS];
    logic [TIME_BITS-1:0] chain_expiry[TIMER_SLOTS];
    status_t              chain_status[TIMER_SLOTS];
    int unsigned          chain_len = 0;

    stq_req_if req_ch ();
    stq_rsp_if rsp_ch ();

    sorted_timer_queue_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [TIME_BITS-1:0] expiry_from(logic [TIMEOUT_W-1:0] tmo);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, now_time} + (TIME_BITS+1)'(tmo);
        return (sum > {1'b0, TIME_TOP}) ? TIME_TOP : sum[TIME_BITS-1:0];
    endfunction

    function automatic int find_position(int slot);
        for (int i = 0; i < chain_len; i++)
        begin
            if (chain_slot[i] == slot)
                return i;
        end
        return -1;
    endfunction

    function automatic void unlink_cell(int pos);
        for (int i = pos; i + 1 < chain_len; i++)
        begin
            chain_slot[i]   = chain_slot[i + 1];
            chain_expiry[i] = chain_expiry[i + 1];
            chain_status[i] = chain_status[i + 1];
        end
        chain_len--;
        chain_status[chain_len] = ST_FREE;
    endfunction

    // A new timer goes behind the last armed cell that is due no later; otherwise in front.
    function automatic void link_cell(logic [SLOT_W-1:0] slot, logic [TIME_BITS-1:0] exp);
        int pos;
        pos = 0;
        for (int i = chain_len; i > 0; i--)
        begin
            if (chain_status[i - 1] == ST_ARMED && exp >= chain_expiry[i - 1])
            begin
                pos = i;
                break;
            end
        end
        for (int i = chain_len; i > pos; i--)
        begin
            chain_slot[i]   = chain_slot[i - 1];
            chain_expiry[i] = chain_expiry[i - 1];
            chain_status[i] = chain_status[i - 1];
        end
        chain_slot[pos]   = slot;
        chain_expiry[pos] = exp;
        chain_status[pos] = ST_ARMED;
        chain_len++;
    endfunction

    function automatic void note_outcome(kind_t kind, logic [ID_W-1:0] slot, logic last);
        outcome_t item;
        item.kind = kind;
        item.slot = slot;
        item.last = last;
        pending_outcomes = {pending_outcomes, item};
    endfunction

    function automatic void apply_request(op_t op, logic [ID_W-1:0] id,
                                          logic [TIMEOUT_W-1:0] tmo);
        int pos;
        int slot;
        logic [SLOT_W-1:0] fired[$];
        if (op == OP_CREATE)
        begin
            if (chain_len >= TIMER_SLOTS)
                note_outcome(KIND_ERROR, '0, 1'b1);
            else
            begin
                slot = 0;
                while (find_position(slot) >= 0)
                    slot++;
                link_cell(SLOT_W'(slot), expiry_from(tmo));
                note_outcome(KIND_CREATED, ID_W'(slot), 1'b1);
            end
        end
        else if (op == OP_CHANGE || op == OP_DELETE)
        begin
            pos = find_position(id);
            if (pos < 0)
                note_outcome(KIND_ERROR, id, 1'b1);
            else
            begin
                unlink_cell(pos);
                if (op == OP_CHANGE)
                begin
                    link_cell(SLOT_W'(id), expiry_from(tmo));
                    note_outcome(KIND_CHANGED, id, 1'b1);
                end
                else
                    note_outcome(KIND_DELETED, id, 1'b1);
            end
        end
        else
        begin
            if (now_time != TIME_TOP)
                now_time++;
            for (pos = 0; pos < chain_len && fired.size() < MAX_RESULTS; pos++)
            begin
                if (chain_status[pos] == ST_ARMED && chain_expiry[pos] <= now_time)
                begin
                    chain_status[pos] = ST_EXPIRED;
                    fired = {fired, chain_slot[pos]};
                end
            end
            for (pos = 0; pos < fired.size(); pos++)
                note_outcome(KIND_EXPIRED, ID_W'(fired[pos]), pos == fired.size() - 1);
        end
    endfunction

    // Entered and left at a falling edge; valid may stay high for the next request.
    task automatic send_request(op_t op, logic [ID_W-1:0] id, logic [TIMEOUT_W-1:0] tmo);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.op       = op;
        req_ch.timer_id = id;
        req_ch.timeout  = tmo;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_request(op, id, tmo);
        @(negedge clk);
    endtask

    function automatic logic [TIMEOUT_W-1:0] pick_timeout();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(6);
        else if (r < 85)
            return $urandom_range(40, 7);
        return $urandom;
    endfunction

    function automatic logic [ID_W-1:0] pick_target_id();
        if (chain_len > 0 && $urandom_range(99) < 75)
            return ID_W'(chain_slot[$urandom_range(chain_len - 1)]);
        return ID_W'($urandom_range(TIMER_SLOTS - 1));
    endfunction

    function automatic void report_mismatch(string note, outcome_t want, outcome_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected kind %0d slot %0d last %0d, ",
                      "got kind %0d slot %0d last %0d"},
                     $realtime, note, want.kind, want.slot, want.last,
                     got.kind, got.slot, got.last);
    endfunction

    task automatic test_free_slot_errors();
        send_request(OP_CHANGE, 4'hF, '0);
        send_request(OP_DELETE, 4'h0, '1);
        send_request(OP_TICK, 4'h5, 32'hA5A5_5A5A);
    endtask

    task automatic test_fill_queue();
        logic [TIMEOUT_W-1:0] tmo;
        for (int n = 0; n < TIMER_SLOTS; n++)
        begin
            if (n == 0)
                tmo = '0;
            else if (n == 1)
                tmo = '1;
            else if (n < 5)
                tmo = 1;
            else
                tmo = 3;
            send_request(OP_CREATE, ID_W'(n), tmo);
        end
        send_request(OP_CREATE, 4'hA, 32'h5A5A_A5A5);
    endtask

    task automatic test_fire_and_rearm();
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '1, '1);
        send_request(OP_CHANGE, 4'h0, '0);
        send_request(OP_TICK, '0, '0);
        send_request(OP_DELETE, 4'h1, '0);
    endtask

    task automatic test_random_traffic();
        int r;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            no_idle = (n >= 120 && n < 220);
            r = $urandom_range(99);
            if (r < 28)
                send_request(OP_CREATE, ID_W'($urandom), pick_timeout());
            else if (r < 45)
                send_request(OP_CHANGE, pick_target_id(), pick_timeout());
            else if (r < 60)
                send_request(OP_DELETE, pick_target_id(), $urandom);
            else
                send_request(OP_TICK, ID_W'($urandom), $urandom);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen.kind = rsp_ch.kind;
            seen.slot = rsp_ch.slot_id;
            seen.last = rsp_ch.last;
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected result", '0, seen);
            else if (seen.kind !== pending_outcomes[0].kind
                     || seen.slot !== pending_outcomes[0].slot
                     || seen.last !== pending_outcomes[0].last)
                report_mismatch("wrong result", pending_outcomes.pop_front(), seen);
            else
                void'(pending_outcomes.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sorted_timer_queue_unit_tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        no_idle         = 1'b0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        req_ch.valid    = 1'b0;
        req_ch.op       = OP_CREATE;
        req_ch.timer_id = '0;
        req_ch.timeout  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_free_slot_errors();
        test_fill_queue();
        test_fire_and_rearm();
        test_random_traffic();
        req_ch.valid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("sorted_timer_queue_unit_tb passed");
        else
            $display("sorted_timer_queue_unit_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/stq_pkg.sv
src/stq_req_if.sv
src/stq_rsp_if.sv
src/stq_cell.sv
src/stq_chain.sv
src/sorted_timer_queue_unit.sv
tb/sv/sorted_timer_queue_unit_tb.sv
